// ===== src/swdk_pkg.sv =====
// Shared constants, types and codes of the key/value stack with delete by key.
package swdk_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int KEY_BITS    = 16;
    localparam int VALUE_BITS  = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int OP_BITS     = 2;
    localparam int STATUS_BITS = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [KEY_BITS-1:0]   wr_key;
        logic [VALUE_BITS-1:0] wr_value;
        logic [ADDR_W-1:0]     rd_addr;
    } mem_req_t;

    typedef struct packed {
        status_t               status;
        logic [VALUE_BITS-1:0] value;
        logic [CNT_W-1:0]      fill;
    } result_t;

endpackage

// ===== src/swdk_mem.sv =====
// Entry store: key and value arrays, one write port, one registered read port.
module swdk_mem (
    input  logic                            clk,
    input  swdk_pkg::mem_req_t              req,
    output logic [swdk_pkg::KEY_BITS-1:0]   rd_key,
    output logic [swdk_pkg::VALUE_BITS-1:0] rd_value
);

    logic [swdk_pkg::KEY_BITS-1:0]   key_store   [swdk_pkg::STACK_DEPTH];
    logic [swdk_pkg::VALUE_BITS-1:0] value_store [swdk_pkg::STACK_DEPTH];
    logic [swdk_pkg::KEY_BITS-1:0]   rd_key_reg;
    logic [swdk_pkg::VALUE_BITS-1:0] rd_value_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            key_store[req.wr_addr]   <= req.wr_key;
            value_store[req.wr_addr] <= req.wr_value;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_key_reg   <= key_store[req.rd_addr];
        rd_value_reg <= value_store[req.rd_addr];
    end

    assign rd_key   = rd_key_reg;
    assign rd_value = rd_value_reg;

endmodule

// ===== src/swdk_seq.sv =====
// Sequencer: runs push, pop and remove over the entry store with one key comparator.
module swdk_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  logic [swdk_pkg::OP_BITS-1:0]    cmd_op,
    input  logic [swdk_pkg::KEY_BITS-1:0]   cmd_key,
    input  logic [swdk_pkg::VALUE_BITS-1:0] cmd_value,
    output logic                            res_valid,
    input  logic                            res_ready,
    output swdk_pkg::result_t               res,
    output swdk_pkg::mem_req_t              mem_req,
    input  logic [swdk_pkg::KEY_BITS-1:0]   mem_key,
    input  logic [swdk_pkg::VALUE_BITS-1:0] mem_value
);

    localparam int AW = swdk_pkg::ADDR_W;
    localparam int CW = swdk_pkg::CNT_W;

    swdk_pkg::state_t             state_reg, state_next;
    swdk_pkg::op_t                op_reg, op_next;
    logic [swdk_pkg::KEY_BITS-1:0]   key_reg, key_next;
    logic [swdk_pkg::VALUE_BITS-1:0] value_reg, value_next;
    logic [swdk_pkg::VALUE_BITS-1:0] data_reg, data_next;
    swdk_pkg::status_t            status_reg, status_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [AW-1:0]                idx_reg, idx_next;

    logic [CW-1:0] cnt_dec;
    logic [CW-1:0] idx_inc1;
    logic [CW-1:0] idx_inc2;
    logic [AW-1:0] idx_up;
    logic          key_hit;

    // the one shared compare unit and index arithmetic
    assign cnt_dec  = count_reg - CW'(1);
    assign idx_inc1 = CW'(idx_reg) + CW'(1);
    assign idx_inc2 = CW'(idx_reg) + CW'(2);
    assign idx_up   = idx_inc1[AW-1:0];
    assign key_hit  = (mem_key == key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swdk_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        value_reg  <= value_next;
        data_reg   <= data_next;
        status_reg <= status_next;
        idx_reg    <= idx_next;
    end

    // next state and datapath registers
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        value_next  = value_reg;
        data_next   = data_reg;
        status_next = status_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        case (state_reg)
            swdk_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next     = swdk_pkg::op_t'(cmd_op);
                    key_next    = cmd_key;
                    value_next  = cmd_value;
                    data_next   = '0;
                    status_next = swdk_pkg::ST_OK;
                    state_next  = swdk_pkg::S_EXEC;
                end
            end
            swdk_pkg::S_EXEC:
            begin
                case (op_reg)
                    swdk_pkg::OP_PUSH:
                    begin
                        if (count_reg == CW'(swdk_pkg::STACK_DEPTH))
                            status_next = swdk_pkg::ST_FULL;
                        else
                            count_next = count_reg + CW'(1);
                        state_next = swdk_pkg::S_DONE;
                    end
                    swdk_pkg::OP_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = swdk_pkg::ST_EMPTY;
                            state_next  = swdk_pkg::S_DONE;
                        end
                        else
                        begin
                            count_next = cnt_dec;
                            state_next = swdk_pkg::S_POP_WAIT;
                        end
                    end
                    swdk_pkg::OP_REMOVE:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = swdk_pkg::ST_EMPTY;
                            state_next  = swdk_pkg::S_DONE;
                        end
                        else
                        begin
                            idx_next   = cnt_dec[AW-1:0];
                            state_next = swdk_pkg::S_SRCH_RD;
                        end
                    end
                    default:
                    begin
                        state_next = swdk_pkg::S_DONE;
                    end
                endcase
            end
            swdk_pkg::S_POP_WAIT:
            begin
                data_next  = mem_value;
                state_next = swdk_pkg::S_DONE;
            end
            swdk_pkg::S_SRCH_RD:
            begin
                state_next = swdk_pkg::S_SRCH_CMP;
            end
            swdk_pkg::S_SRCH_CMP:
            begin
                if (key_hit)
                begin
                    if (idx_inc1 < count_reg)
                        state_next = swdk_pkg::S_SHIFT_RD;
                    else
                    begin
                        count_next = cnt_dec;
                        state_next = swdk_pkg::S_DONE;
                    end
                end
                else if (idx_reg == '0)
                begin
                    status_next = swdk_pkg::ST_NOT_FOUND;
                    state_next  = swdk_pkg::S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg - AW'(1);
                    state_next = swdk_pkg::S_SRCH_RD;
                end
            end
            swdk_pkg::S_SHIFT_RD:
            begin
                state_next = swdk_pkg::S_SHIFT_WR;
            end
            swdk_pkg::S_SHIFT_WR:
            begin
                idx_next = idx_up;
                if (idx_inc2 < count_reg)
                    state_next = swdk_pkg::S_SHIFT_RD;
                else
                begin
                    count_next = cnt_dec;
                    state_next = swdk_pkg::S_DONE;
                end
            end
            swdk_pkg::S_DONE:
            begin
                if (res_ready)
                    state_next = swdk_pkg::S_IDLE;
            end
            default:
            begin
                state_next = swdk_pkg::S_IDLE;
            end
        endcase
    end

    // store port and handshake outputs
    always_comb
    begin
        mem_req          = '0;
        mem_req.wr_key   = key_reg;
        mem_req.wr_value = value_reg;
        mem_req.rd_addr  = idx_reg;
        cmd_ready        = 1'b0;
        res_valid        = 1'b0;
        case (state_reg)
            swdk_pkg::S_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            swdk_pkg::S_EXEC:
            begin
                mem_req.rd_addr = cnt_dec[AW-1:0];
                if (op_reg == swdk_pkg::OP_PUSH
                    && count_reg != CW'(swdk_pkg::STACK_DEPTH))
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = count_reg[AW-1:0];
                end
            end
            swdk_pkg::S_SHIFT_RD:
            begin
                mem_req.rd_addr = idx_up;
            end
            swdk_pkg::S_SHIFT_WR:
            begin
                mem_req.wr_en    = 1'b1;
                mem_req.wr_addr  = idx_reg;
                mem_req.wr_key   = mem_key;
                mem_req.wr_value = mem_value;
            end
            swdk_pkg::S_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    assign res.status = status_reg;
    assign res.value  = data_reg;
    assign res.fill   = count_reg;

endmodule

// ===== src/stack_with_delete_by_key.sv =====
// Top level of the bounded key/value stack with delete by key.
//
// Input channel s_axis: one item is one operation. s_axis_tuser carries the
// operation code (push, pop, remove by key; code 3 does nothing), s_axis_tdata
// carries the key in bits 15:0 and the data word in bits 47:16.
// Output channel m_axis: exactly one item per operation. m_axis_tuser is the
// status (ok, empty, key not found, full), m_axis_tdata holds the popped data
// in bits 31:0 (zero unless a pop succeeded) and the fill level after the
// operation in bits 36:32.
// Path from accept to the result: a push or an unused code passes the execute
// and done states; a pop adds a read wait state between them unless the stack
// is empty. A remove walks from the top down, reading and comparing one entry
// at a time, then closes the gap by moving each entry above the hit down one
// place, read then write, via the single read and write port of the entry store.
// One operation is in flight at a time; s_axis_tready is high only while the
// sequencer is idle, so no item is taken before the last result is handed on.
// A finished result sits in the output register, so the next operation is
// accepted while m_axis is stalled; it then waits at its end for the register.
// Reset clears the entry count (empty stack) and the control state; the
// store contents are left as they are and are never read before written.
module stack_with_delete_by_key (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // item_key[15:0], item_value[47:16]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // popped_value[31:0], fill_level[36:32], zero pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    swdk_pkg::mem_req_t              mem_req;
    logic [swdk_pkg::KEY_BITS-1:0]   mem_key;
    logic [swdk_pkg::VALUE_BITS-1:0] mem_value;
    swdk_pkg::result_t               res;
    logic                            res_valid;
    logic                            res_ready;

    logic              out_valid_reg;
    swdk_pkg::result_t out_res_reg;

    swdk_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_axis_tvalid),
        .cmd_ready (s_axis_tready),
        .cmd_op    (s_axis_tuser),
        .cmd_key   (s_axis_tdata[swdk_pkg::KEY_BITS-1:0]),
        .cmd_value (s_axis_tdata[47:16]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .mem_key   (mem_key),
        .mem_value (mem_value)
    );

    swdk_mem u_mem (
        .clk      (clk),
        .req      (mem_req),
        .rd_key   (mem_key),
        .rd_value (mem_value)
    );

    // output register: loads when empty or being drained this cycle
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            out_res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.status;
    assign m_axis_tdata  = {3'b000, out_res_reg.fill, out_res_reg.value};

endmodule

// ===== src/swdk_chk.sv =====
// Port-level checker for the key/value stack, bound to the top level.
module swdk_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // fill level never goes past the stack depth
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[36:32] <= swdk_pkg::CNT_W'(swdk_pkg::STACK_DEPTH))
        else $error("fill level beyond stack depth");

    // a full status only comes with a full stack
    a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == swdk_pkg::ST_FULL)
        |-> m_axis_tdata[36:32] == swdk_pkg::CNT_W'(swdk_pkg::STACK_DEPTH))
        else $error("full status with room left");

    // an empty status only comes with an empty stack
    a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == swdk_pkg::ST_EMPTY)
        |-> m_axis_tdata[36:32] == '0)
        else $error("empty status with entries held");

    // popped data is zero unless the status is ok
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != swdk_pkg::ST_OK)
        |-> m_axis_tdata[31:0] == '0)
        else $error("popped data on a failed operation");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind stack_with_delete_by_key swdk_chk u_swdk_chk (.*);
